[src/int4_weight_dot_product_unit_macros.svh]
// Assertion helpers used by the top-level RTL
`ifndef INT4_WEIGHT_DOT_PRODUCT_UNIT_MACROS_SVH
`define INT4_WEIGHT_DOT_PRODUCT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IWDP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define IWDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/iwdp_pkg.sv]
package iwdp_pkg;

   localparam int X_W       = 16;
   localparam int NIB_W     = 4;
   localparam int PROD_W    = X_W + NIB_W;
   localparam int ACC_W     = 48;
   localparam int SUM_W     = ACC_W + 2;
   localparam int SCALE_W   = 16;
   localparam int HALF_W    = ACC_W / 2;
   localparam int HI_W      = HALF_W + SCALE_W;
   localparam int LO_W      = HALF_W + 1 + SCALE_W;
   localparam int LOR_W     = LO_W + 1;
   localparam int FULL_W    = 64;
   localparam int FRAC_BITS = 12;
   localparam int RND_W     = FULL_W - FRAC_BITS;
   localparam int DOT_W     = 32;

   localparam logic signed [LOR_W-1:0] ROUND_BIAS = LOR_W'(1 << (FRAC_BITS - 1));

   localparam logic signed [SUM_W-1:0] ACC_MAX_WIDE = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] ACC_MIN_WIDE = -SUM_W'(64'sd1 <<< (ACC_W - 1));

   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SCALE_W-1:0] scale_type;

   // Finished vector sum handed from the accumulator to the scaler
   typedef struct packed {
      logic      valid;
      acc_type   sum;
      logic      ovf;
      scale_type scale;
   } handoff_type;

   // Accumulator-side status for checking
   typedef struct packed {
      logic s1_valid;
      logic s1_last;
      logic acc_zero;
   } merge_status_type;

   // Map an offset-8 nibble to its signed weight (-8 to 7)
   function automatic logic signed [NIB_W-1:0] nib_weight(input logic [NIB_W-1:0] nib);
      return $signed({~nib[NIB_W-1], nib[NIB_W-2:0]});
   endfunction

endpackage

[src/int4_weight_dot_product_unit.sv]
// Streaming dot product of Q4.12 activation pairs with packed 4-bit weights
// (high nibble with x_first, low nibble with x_second, each offset by 8).
// Two multiplier lanes feed a 48-bit saturating accumulator. A pair is taken
// every cycle while the lane stage can move on. A pair with last waits in the
// lane stage until the scaler is empty, and the input is stalled while it
// waits. Its result (sum times scale_q, rounded half up to Q.12 and clamped
// to 32 bits) is registered in the scaler's input, half-product and output
// registers in turn once the pair leaves the lane stage. The 48x16 scale
// multiply runs as two half products over two pipeline stages. The
// scaler holds one vector result at a time, so a last pair that arrives
// before the previous result has been taken holds the input until then.
// saturated flags a clamp in either the accumulator or the final value.
`include "int4_weight_dot_product_unit_macros.svh"

module int4_weight_dot_product_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [15:0]                  req_x_first,
   input  logic signed [15:0]                  req_x_second,
   input  logic        [7:0]                   req_packed_weights,
   input  logic signed [15:0]                  req_scale_q,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_dot_value,
   output logic                                rsp_saturated
);

   logic                           load;
   logic                           scale_free;
   iwdp_pkg::prod_type             prod_a, prod_b;
   iwdp_pkg::handoff_type          handoff;
   iwdp_pkg::merge_status_type     status;

   // High nibble lane
   iwdp_lane u_lane_a (
      .clock  (clock),
      .load   (load),
      .x      (req_x_first),
      .nibble (req_packed_weights[2*iwdp_pkg::NIB_W-1:iwdp_pkg::NIB_W]),
      .prod   (prod_a)
   );

   // Low nibble lane
   iwdp_lane u_lane_b (
      .clock  (clock),
      .load   (load),
      .x      (req_x_second),
      .nibble (req_packed_weights[iwdp_pkg::NIB_W-1:0]),
      .prod   (prod_b)
   );

   iwdp_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_last    (req_last),
      .req_scale_q (req_scale_q),
      .prod_a      (prod_a),
      .prod_b      (prod_b),
      .scale_free  (scale_free),
      .load        (load),
      .in_stall    (req_stall),
      .handoff     (handoff),
      .status      (status)
   );

   iwdp_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .handoff       (handoff),
      .rsp_stall     (rsp_stall),
      .scale_free    (scale_free),
      .rsp_valid     (rsp_valid),
      .rsp_dot_value (rsp_dot_value),
      .rsp_saturated (rsp_saturated)
   );

   // Stall only while a last pair waits on the scaler
   `IWDP_ASSERT_NOW(a_stall_cause, clock, reset, req_stall,
      status.s1_valid && status.s1_last && !scale_free, "stall without pending last pair")

   // Scaler never receives a second vector while busy
   `IWDP_ASSERT_NOW(a_handoff_free, clock, reset, handoff.valid, scale_free,
      "handoff into busy scaler")

   // Accumulator and overflow flag clear after a vector completes
   `IWDP_ASSERT_NEXT(a_acc_clear, clock, reset, handoff.valid, status.acc_zero,
      "accumulator not cleared after last pair")

   // A result appears on the scaler output for each handoff
   `IWDP_ASSERT_NEXT(a_result_follows, clock, reset,
      handoff.valid ##2 1'b1, rsp_valid, "result missing after handoff")

endmodule

[src/iwdp_lane.sv]
module iwdp_lane (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [iwdp_pkg::X_W-1:0]     x,
   input  logic        [iwdp_pkg::NIB_W-1:0]   nibble,
   output iwdp_pkg::prod_type                  prod
);

   iwdp_pkg::prod_type prod_ff;
   iwdp_pkg::prod_type prod_in;

   // Multiply activation by the decoded signed weight
   always_comb begin
      prod_in = iwdp_pkg::PROD_W'(x * iwdp_pkg::nib_weight(nibble));
   end

   // Capture product on each input transfer
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[src/iwdp_merge.sv]
module iwdp_merge (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_last,
   input  iwdp_pkg::scale_type            req_scale_q,
   input  iwdp_pkg::prod_type             prod_a,
   input  iwdp_pkg::prod_type             prod_b,
   input  logic                           scale_free,
   output logic                           load,
   output logic                           in_stall,
   output iwdp_pkg::handoff_type          handoff,
   output iwdp_pkg::merge_status_type     status
);

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_last_ff;
   iwdp_pkg::scale_type           s1_scale_ff;
   iwdp_pkg::acc_type             acc_ff, acc_in;
   logic                          ovf_ff, ovf_in;
   logic                          advance;
   logic signed [iwdp_pkg::SUM_W-1:0] sum_wide;
   iwdp_pkg::acc_type             sum_sat;
   logic                          hit;

   // A last pair waits in the lane stage until the scaler is empty
   always_comb begin
      advance     = s1_valid_ff & (~s1_last_ff | scale_free);
      in_stall    = s1_valid_ff & ~advance;
      load        = req_valid & ~in_stall;
      s1_valid_in = load | (s1_valid_ff & ~advance);
   end

   // Merge both lane products into the accumulator, clamping at 48 bits
   always_comb begin
      sum_wide = iwdp_pkg::SUM_W'(acc_ff) + iwdp_pkg::SUM_W'(prod_a)
               + iwdp_pkg::SUM_W'(prod_b);
      hit      = 1'b0;
      priority if (sum_wide > iwdp_pkg::ACC_MAX_WIDE) begin
         sum_sat = iwdp_pkg::ACC_W'(iwdp_pkg::ACC_MAX_WIDE);
         hit     = 1'b1;
      end else if (sum_wide < iwdp_pkg::ACC_MIN_WIDE) begin
         sum_sat = iwdp_pkg::ACC_W'(iwdp_pkg::ACC_MIN_WIDE);
         hit     = 1'b1;
      end else begin
         sum_sat = iwdp_pkg::ACC_W'(sum_wide);
      end
   end

   // Update or clear the running sum
   always_comb begin
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      if (advance) begin
         if (s1_last_ff) begin
            acc_in = '0;
            ovf_in = 1'b0;
         end else begin
            acc_in = sum_sat;
            ovf_in = ovf_ff | hit;
         end
      end
   end

   always_comb begin
      handoff.valid = advance & s1_last_ff;
      handoff.sum   = sum_sat;
      handoff.ovf   = ovf_ff | hit;
      handoff.scale = s1_scale_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
      end
   end

   // Hold item control alongside the lane products
   always_ff @(posedge clock) begin
      if (load) begin
         s1_last_ff  <= req_last;
         s1_scale_ff <= req_scale_q;
      end
   end

   always_comb begin
      status.s1_valid = s1_valid_ff;
      status.s1_last  = s1_last_ff;
      status.acc_zero = (acc_ff == '0) & ~ovf_ff;
   end

endmodule

[src/iwdp_scale.sv]
module iwdp_scale (
   input  logic                                 clock,
   input  logic                                 reset,
   input  iwdp_pkg::handoff_type                handoff,
   input  logic                                 rsp_stall,
   output logic                                 scale_free,
   output logic                                 rsp_valid,
   output logic signed [iwdp_pkg::DOT_W-1:0]    rsp_dot_value,
   output logic                                 rsp_saturated
);

   logic                                   a_valid_ff;
   iwdp_pkg::acc_type                      a_sum_ff;
   iwdp_pkg::scale_type                    a_scale_ff;
   logic                                   a_ovf_ff;
   logic                                   b_valid_ff;
   logic signed [iwdp_pkg::HI_W-1:0]       hi_ff, hi_in;
   logic signed [iwdp_pkg::LOR_W-1:0]      lo_ff, lo_in;
   logic signed [iwdp_pkg::LO_W-1:0]       lo_prod;
   logic                                   b_ovf_ff;
   logic                                   out_valid_ff, out_valid_in;
   logic signed [iwdp_pkg::DOT_W-1:0]      dot_ff, dot_in;
   logic                                   sat_ff, sat_in;
   logic signed [iwdp_pkg::FULL_W-1:0]     full;
   logic signed [iwdp_pkg::RND_W-1:0]      rounded;

   assign scale_free = ~a_valid_ff & ~b_valid_ff & ~out_valid_ff;

   // Split the 48-bit sum into halves and multiply each by the scale
   always_comb begin
      hi_in   = iwdp_pkg::HI_W'($signed(a_sum_ff[iwdp_pkg::ACC_W-1:iwdp_pkg::HALF_W])
                * a_scale_ff);
      lo_prod = $signed({1'b0, a_sum_ff[iwdp_pkg::HALF_W-1:0]}) * a_scale_ff;
      lo_in   = iwdp_pkg::LOR_W'(lo_prod) + iwdp_pkg::ROUND_BIAS;
   end

   // Recombine, drop fraction bits (floor), clamp to 32 bits
   always_comb begin
      full    = {hi_ff, iwdp_pkg::HALF_W'(0)} + iwdp_pkg::FULL_W'(lo_ff);
      rounded = full[iwdp_pkg::FULL_W-1:iwdp_pkg::FRAC_BITS];
      sat_in  = b_ovf_ff;
      priority if (rounded > iwdp_pkg::RND_W'(64'sh7FFF_FFFF)) begin
         dot_in = {1'b0, {(iwdp_pkg::DOT_W-1){1'b1}}};
         sat_in = 1'b1;
      end else if (rounded < -iwdp_pkg::RND_W'(64'sh8000_0000)) begin
         dot_in = {1'b1, {(iwdp_pkg::DOT_W-1){1'b0}}};
         sat_in = 1'b1;
      end else begin
         dot_in = rounded[iwdp_pkg::DOT_W-1:0];
      end
   end

   // Hold the result until the transfer completes
   assign out_valid_in = b_valid_ff | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= handoff.valid;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (handoff.valid) begin
         a_sum_ff   <= handoff.sum;
         a_scale_ff <= handoff.scale;
         a_ovf_ff   <= handoff.ovf;
      end
      if (a_valid_ff) begin
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         b_ovf_ff <= a_ovf_ff;
      end
      if (b_valid_ff) begin
         dot_ff <= dot_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_dot_value = dot_ff;
   assign rsp_saturated = sat_ff;

endmodule
